@@ rtl/monochrome_sprite_xor_framebuffer_top_defines.svh @@
// Assertion macros for the sprite frame store.
`ifndef MONOCHROME_SPRITE_XOR_FRAMEBUFFER_TOP_DEFINES_SVH
`define MONOCHROME_SPRITE_XOR_FRAMEBUFFER_TOP_DEFINES_SVH

// Same-cycle implication, reset masked.
`define MSXF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, reset masked.
`define MSXF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/msxf_pkg.sv @@
// Shared types, codes and constants for the sprite frame store.
package msxf_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF    = 64;
  localparam int unsigned SCREEN_HEIGHT_DEF   = 32;
  localparam int unsigned MAX_SPRITE_ROWS_DEF = 16;

  localparam int unsigned REQ_W     = 2;
  localparam int unsigned XPOS_W    = 6;
  localparam int unsigned YPOS_W    = 5;
  localparam int unsigned RIDX_W    = 4;
  localparam int unsigned SPRITE_W  = 8;   // one lane per sprite bit
  localparam int unsigned TAB_AW    = 6;   // covers x_pos and y_pos + row_index
  localparam int unsigned TAB_DEPTH = 1 << TAB_AW;

  typedef enum logic [REQ_W-1:0] {
    REQ_SET   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_DRAW  = 2'd3
  } req_t;

  // Merge stage decisions handed back to the control and store.
  typedef struct packed {
    logic wr_en;
    logic clr_all;
    logic hit_next;
    logic pixel;
    logic collision;
  } merge_ctl_t;

endpackage

@@ rtl/msxf_lane.sv @@
// One sprite-bit lane: wrapped column, column mask and collision test.
module msxf_lane #(
  parameter int unsigned SCREEN_WIDTH = msxf_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned LANE         = 0
) (
  input  logic [$clog2(SCREEN_WIDTH)-1:0] col_base,
  input  logic                            lit,
  input  logic [SCREEN_WIDTH-1:0]         row_word,
  output logic [SCREEN_WIDTH-1:0]         col_mask,
  output logic [SCREEN_WIDTH-1:0]         put_mask,
  output logic                            hit
);
  import msxf_pkg::*;

  localparam int unsigned CW = $clog2(SCREEN_WIDTH);

  logic [CW:0]   col_sum;
  logic [CW-1:0] col;

  // col_base < width and lane < 8 <= width, so one subtract wraps it
  always_comb begin
    col_sum = {1'b0, col_base} + (CW+1)'(LANE);
    if (col_sum >= (CW+1)'(SCREEN_WIDTH)) begin
      col_sum = col_sum - (CW+1)'(SCREEN_WIDTH);
    end
    col = col_sum[CW-1:0];
  end

  assign col_mask = SCREEN_WIDTH'(1) << col;
  assign put_mask = lit ? col_mask : '0;
  assign hit      = lit & row_word[col];

endmodule

@@ rtl/msxf_merge.sv @@
// Merge stage: combines lane masks into the new row word and result flags.
module msxf_merge #(
  parameter int unsigned SCREEN_WIDTH = msxf_pkg::SCREEN_WIDTH_DEF
) (
  input  msxf_pkg::req_t                                      req,
  input  logic                                                ri_ok,
  input  logic                                                ri_zero,
  input  logic                                                hit_flag,
  input  logic [SCREEN_WIDTH-1:0]                             row_word,
  input  logic [msxf_pkg::SPRITE_W-1:0][SCREEN_WIDTH-1:0]     lane_col,
  input  logic [msxf_pkg::SPRITE_W-1:0][SCREEN_WIDTH-1:0]     lane_put,
  input  logic [msxf_pkg::SPRITE_W-1:0]                       lane_hit,
  output logic [SCREEN_WIDTH-1:0]                             new_row,
  output msxf_pkg::merge_ctl_t                                ctl
);
  import msxf_pkg::*;

  logic [SCREEN_WIDTH-1:0] draw_mask;

  always_comb begin
    draw_mask = '0;
    for (int b = 0; b < SPRITE_W; b++) begin
      draw_mask = draw_mask | lane_put[b];
    end
  end

  always_comb begin
    ctl          = '0;
    ctl.hit_next = hit_flag;
    new_row      = row_word;
    case (req)
      REQ_SET: begin
        new_row    = row_word | lane_col[0];
        ctl.wr_en  = 1'b1;
      end
      REQ_CLEAR: begin
        ctl.clr_all = 1'b1;
      end
      REQ_QUERY: begin
        ctl.pixel = |(row_word & lane_col[0]);
      end
      REQ_DRAW: begin
        if (ri_ok) begin
          ctl.hit_next = (hit_flag & ~ri_zero) | (|lane_hit);
          new_row      = row_word ^ draw_mask;
          ctl.wr_en    = 1'b1;
        end
        ctl.collision = ctl.hit_next;
      end
      default: begin
        ctl.hit_next = hit_flag;
      end
    endcase
  end

endmodule

@@ rtl/monochrome_sprite_xor_framebuffer_top.sv @@
// Top level of the one-bit-per-pixel sprite frame store.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------------
//   in      | in_valid / in_stall  | req_type x_pos y_pos row_index row_bits last_row
//   out     | out_valid / out_stall| pixel_on collision
//
// A request is taken in S_IDLE, which reads its row word from the row memory;
// S_EXEC then runs the eight lanes, the merge and the write-back. A new request is
// taken only back in S_IDLE, once the last is done; a result held by out_stall delays the write-back.
// Clear drops all the per-row valid bits at once at write-back, so it costs the same.
// Reset (synchronous) blanks the screen the same way and zeroes the hit flag.
module monochrome_sprite_xor_framebuffer_top #(
  parameter int unsigned SCREEN_WIDTH    = msxf_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT   = msxf_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned MAX_SPRITE_ROWS = msxf_pkg::MAX_SPRITE_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [msxf_pkg::REQ_W-1:0]    req_type,
  input  logic [msxf_pkg::XPOS_W-1:0]   x_pos,
  input  logic [msxf_pkg::YPOS_W-1:0]   y_pos,
  input  logic [msxf_pkg::RIDX_W-1:0]   row_index,
  input  logic [msxf_pkg::SPRITE_W-1:0] row_bits,
  input  logic                          last_row,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          pixel_on,
  output logic                          collision
);
  import msxf_pkg::*;
  `include "monochrome_sprite_xor_framebuffer_top_defines.svh"

  localparam int unsigned CW = $clog2(SCREEN_WIDTH);
  localparam int unsigned RW = $clog2(SCREEN_HEIGHT);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  // constant wrap tables: index mod width, index mod height
  logic [TAB_DEPTH-1:0][CW-1:0] xmod_tab;
  logic [TAB_DEPTH-1:0][RW-1:0] ymod_tab;

  for (genvar i = 0; i < TAB_DEPTH; i++) begin : g_tab
    localparam int unsigned XM = i % SCREEN_WIDTH;
    localparam int unsigned YM = i % SCREEN_HEIGHT;
    assign xmod_tab[i] = CW'(XM);
    assign ymod_tab[i] = RW'(YM);
  end

  logic                    in_xfer;
  logic                    done;
  logic [TAB_AW-1:0]       row_sum;
  logic [RW-1:0]           rd_addr;

  // latched request
  req_t                    req_r;
  logic [CW-1:0]           col_base;
  logic [SPRITE_W-1:0]     row_bits_r;
  logic                    ri_ok;
  logic                    ri_zero;
  logic [RW-1:0]           addr_r;

  // row memory with per-row valid bits (invalid row reads as blank)
  logic [SCREEN_WIDTH-1:0] mem [SCREEN_HEIGHT];
  logic [SCREEN_WIDTH-1:0] rd_data;
  logic                    rd_valid;
  logic [SCREEN_HEIGHT-1:0] row_valid;
  logic [SCREEN_WIDTH-1:0] row_word;

  logic                    hit_flag;

  logic [SPRITE_W-1:0][SCREEN_WIDTH-1:0] lane_col;
  logic [SPRITE_W-1:0][SCREEN_WIDTH-1:0] lane_put;
  logic [SPRITE_W-1:0]                   lane_hit;
  logic [SCREEN_WIDTH-1:0]               new_row;
  merge_ctl_t                            ctl;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid & ~in_stall;
  assign done     = (state == S_EXEC) & ~(out_valid & out_stall);

  assign row_sum  = {1'b0, y_pos} +
                    ((req_t'(req_type) == REQ_DRAW) ? TAB_AW'(row_index) : '0);
  assign rd_addr  = ymod_tab[row_sum];
  assign row_word = rd_valid ? rd_data : '0;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_xfer) state_next = S_EXEC;
      S_EXEC: if (done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_valid <= '0;
      hit_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (done) begin
        out_valid <= 1'b1;
        hit_flag  <= ctl.hit_next;
        if (ctl.clr_all) begin
          row_valid <= '0;
        end else if (ctl.wr_en) begin
          row_valid[addr_r] <= 1'b1;
        end
      end else if (out_valid & ~out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request latch and row read on transfer, row write-back when done
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r      <= req_t'(req_type);
      col_base   <= xmod_tab[x_pos];
      row_bits_r <= row_bits;
      ri_ok      <= ({1'b0, row_index} < (RIDX_W+1)'(MAX_SPRITE_ROWS));
      ri_zero    <= (row_index == '0);
      addr_r     <= rd_addr;
      rd_data    <= mem[rd_addr];
      rd_valid   <= row_valid[rd_addr];
    end
    if (done & ctl.wr_en) begin
      mem[addr_r] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      pixel_on  <= ctl.pixel;
      collision <= ctl.collision;
    end
  end

  // lane b handles sprite bit 7-b, landing at column x + b
  for (genvar b = 0; b < SPRITE_W; b++) begin : g_lane
    msxf_lane #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .LANE         (b)
    ) u_lane (
      .col_base (col_base),
      .lit      (row_bits_r[SPRITE_W-1-b]),
      .row_word (row_word),
      .col_mask (lane_col[b]),
      .put_mask (lane_put[b]),
      .hit      (lane_hit[b])
    );
  end

  msxf_merge #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_merge (
    .req      (req_r),
    .ri_ok    (ri_ok),
    .ri_zero  (ri_zero),
    .hit_flag (hit_flag),
    .row_word (row_word),
    .lane_col (lane_col),
    .lane_put (lane_put),
    .lane_hit (lane_hit),
    .new_row  (new_row),
    .ctl      (ctl)
  );

  // last_row is informational: the collision on that row is already final
  `MSXF_ASSERT_NEXT(a_xfer_starts_work, in_xfer, state == S_EXEC, "transfer did not start work")
  `MSXF_ASSERT_NEXT(a_pixel_only_query, done && req_r != REQ_QUERY, !pixel_on, "pixel_on set outside query")
  `MSXF_ASSERT_NEXT(a_clear_blanks, done && req_r == REQ_CLEAR, row_valid == '0, "clear left rows valid")
  `MSXF_ASSERT_NOW(a_coll_only_draw, out_valid && collision, hit_flag, "collision without hit flag")
  `MSXF_ASSERT_NEXT(a_result_follows, done, out_valid, "finished request gave no result")

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the sprite frame store: directed and random requests.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msxf_pkg::*;

  localparam int unsigned ROWS       = SCREEN_HEIGHT_DEF;
  localparam int unsigned COLS       = SCREEN_WIDTH_DEF;
  localparam int unsigned HOLD_AT    = 200;   // inputs taken before the long output hold
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned QUIET_MAX  = 4000;  // cycles with no transfer before giving up
  localparam int unsigned PHASE_SIZE = 240;

  // idling phases
  localparam int MODE_FREE     = 0;
  localparam int MODE_SRC_IDLE = 1;
  localparam int MODE_DST_STALL = 2;
  localparam int MODE_BOTH     = 3;

  typedef struct {
    req_t                req;
    logic [XPOS_W-1:0]   x;
    logic [YPOS_W-1:0]   y;
    logic [RIDX_W-1:0]   ri;
    logic [SPRITE_W-1:0] bits;
    logic                last;
    int                  mode;
    bit                  drain;
  } request_t;

  typedef struct {
    logic pixel;
    logic hit;
  } pixel_result_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [REQ_W-1:0]    req_type;
  logic [XPOS_W-1:0]   x_pos;
  logic [YPOS_W-1:0]   y_pos;
  logic [RIDX_W-1:0]   row_index;
  logic [SPRITE_W-1:0] row_bits;
  logic                last_row;
  logic                out_valid;
  logic                out_stall;
  logic                pixel_on;
  logic                collision;

  monochrome_sprite_xor_framebuffer_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .x_pos     (x_pos),
    .y_pos     (y_pos),
    .row_index (row_index),
    .row_bits  (row_bits),
    .last_row  (last_row),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_on  (pixel_on),
    .collision (collision)
  );

  // shadow of the frame store
  logic [COLS-1:0] frame_pixels [ROWS];
  logic            sprite_hit;

  request_t      pending_requests [$];
  pixel_result_t expected_results [$];
  request_t      offered;
  bit            in_taken;
  int            cur_mode;
  int unsigned   n_in;
  int unsigned   n_errors;
  int unsigned   quiet_cycles;
  int            gen_mode;
  bit            gen_drain;

  function automatic pixel_result_t apply_request(request_t rq);
    pixel_result_t   r;
    logic [COLS-1:0] mask;
    logic [XPOS_W-1:0] col;
    logic [YPOS_W-1:0] slot;
    r.pixel = 1'b0;
    r.hit   = 1'b0;
    case (rq.req)
      REQ_SET: frame_pixels[rq.y][rq.x] = 1'b1;
      REQ_CLEAR: begin
        for (int i = 0; i < ROWS; i++) frame_pixels[i] = '0;
      end
      REQ_QUERY: r.pixel = frame_pixels[rq.y][rq.x];
      default: begin
        mask = '0;
        // MSB lands on the start column, columns wrap
        for (int b = 0; b < SPRITE_W; b++) begin
          if (rq.bits[SPRITE_W-1-b]) begin
            col       = rq.x + XPOS_W'(b);
            mask[col] = 1'b1;
          end
        end
        slot = rq.y + YPOS_W'(rq.ri);
        if (rq.ri == '0) sprite_hit = 1'b0;
        if ((frame_pixels[slot] & mask) != '0) sprite_hit = 1'b1;
        frame_pixels[slot] ^= mask;
        r.hit = sprite_hit;
      end
    endcase
    return r;
  endfunction

  task automatic add_request(req_t req, int x, int y, int ri, int bits, int last);
    request_t rq;
    rq.req   = req;
    rq.x     = XPOS_W'(x);
    rq.y     = YPOS_W'(y);
    rq.ri    = RIDX_W'(ri);
    rq.bits  = SPRITE_W'(bits);
    rq.last  = 1'(last);
    rq.mode  = gen_mode;
    rq.drain = gen_drain;
    gen_drain = 1'b0;
    pending_requests.push_back(rq);
  endtask

  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  // sender
  always @(negedge clk) begin
    bit idle;
    if (!rst && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      idle = 1'b1;
      if (pending_requests.size() != 0) begin
        // a drain marker holds the sender until the pipeline is empty
        if (pending_requests[0].drain && expected_results.size() == 0)
          pending_requests[0].drain = 1'b0;
        if (!pending_requests[0].drain) begin
          case (pending_requests[0].mode)
            MODE_SRC_IDLE: idle = ($urandom_range(99) < 75);
            MODE_BOTH:     idle = ($urandom_range(99) < 18);
            default:       idle = 1'b0;
          endcase
        end
      end
      if (!idle) begin
        offered = pending_requests.pop_front();
        req_type  <= offered.req;
        x_pos     <= offered.x;
        y_pos     <= offered.y;
        row_index <= offered.ri;
        row_bits  <= offered.bits;
        last_row  <= offered.last;
      end
      in_valid <= !idle;
    end
  end

  // receiver
  always @(negedge clk) begin
    int unsigned hold_left;
    bit          hold_done;
    if (!hold_done && n_in >= HOLD_AT) begin
      hold_left = HOLD_LEN;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (cur_mode)
        MODE_DST_STALL: out_stall <= ($urandom_range(99) < 75);
        MODE_BOTH:      out_stall <= ($urandom_range(99) < 18);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  // input and output transfers, checking, watchdog
  always @(posedge clk) begin
    pixel_result_t want;
    bit            moved;
    moved = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_request(offered));
        in_taken = 1'b1;
        cur_mode = offered.mode;
        n_in++;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got pixel_on %0b collision %0b",
                   $time, pixel_on, collision);
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          if (pixel_on !== want.pixel) begin
            $display("%0t: pixel_on mismatch, expected %0b, got %0b",
                     $time, want.pixel, pixel_on);
            n_errors++;
          end
          if (collision !== want.hit) begin
            $display("%0t: collision mismatch, expected %0b, got %0b",
                     $time, want.hit, collision);
            n_errors++;
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int              kind;
    int              n_rows;
    int              sx;
    int              sy;
    int              r;
    logic [SPRITE_W-1:0] spr [16];

    rst       = 1'b1;
    in_valid  = 1'b0;
    out_stall = 1'b0;
    req_type  = '0;
    x_pos     = '0;
    y_pos     = '0;
    row_index = '0;
    row_bits  = '0;
    last_row  = 1'b0;
    in_taken  = 1'b0;
    cur_mode  = MODE_FREE;
    n_in      = 0;
    n_errors  = 0;
    quiet_cycles = 0;
    sprite_hit = 1'b0;
    for (int i = 0; i < ROWS; i++) frame_pixels[i] = '0;

    // directed part
    gen_mode  = MODE_FREE;
    gen_drain = 1'b0;
    add_request(REQ_QUERY, 0, 0, 0, 0, 0);
    add_request(REQ_SET, 0, 0, 15, 255, 1);
    add_request(REQ_SET, 63, 31, 0, 0, 0);
    add_request(REQ_QUERY, 63, 31, 15, 255, 1);
    add_request(REQ_QUERY, 0, 0, 0, 0, 0);
    add_request(REQ_QUERY, 1, 0, 0, 0, 0);
    // sprite wrapping across the right edge and the bottom
    add_request(REQ_DRAW, 60, 30, 0, 8'hFF, 0);
    add_request(REQ_DRAW, 60, 30, 1, 8'hFF, 0);
    add_request(REQ_DRAW, 60, 30, 2, 8'h10, 1);
    add_request(REQ_QUERY, 0, 0, 0, 0, 0);
    add_request(REQ_QUERY, 63, 31, 0, 0, 0);
    // redraw restarts the flag at row zero, then a blank row zero clears it
    add_request(REQ_DRAW, 60, 30, 0, 8'hFF, 1);
    add_request(REQ_DRAW, 60, 30, 0, 8'h00, 1);
    add_request(REQ_DRAW, 63, 0, 0, 8'h01, 0);
    add_request(REQ_QUERY, 6, 0, 0, 0, 0);
    add_request(REQ_DRAW, 63, 31, 15, 8'hA5, 1);
    add_request(REQ_QUERY, 63, 14, 0, 0, 0);
    // clear leaves the collision flag alone
    add_request(REQ_DRAW, 6, 0, 0, 8'h80, 0);
    add_request(REQ_CLEAR, 63, 31, 15, 255, 1);
    add_request(REQ_DRAW, 0, 5, 1, 8'h00, 1);
    add_request(REQ_QUERY, 60, 30, 0, 0, 0);
    add_request(REQ_SET, 5, 7, 0, 0, 0);
    add_request(REQ_QUERY, 5, 7, 9, 8'h5A, 1);
    add_request(REQ_CLEAR, 0, 0, 0, 0, 0);
    add_request(REQ_QUERY, 5, 7, 0, 0, 0);

    // random part, one idling phase after another, each starting from an empty pipeline
    sx = 0;
    sy = 0;
    n_rows = 1;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1:       gen_mode = MODE_SRC_IDLE;
        2:       gen_mode = MODE_DST_STALL;
        3:       gen_mode = MODE_BOTH;
        default: gen_mode = MODE_FREE;
      endcase
      gen_drain = 1'b1;
      while (pending_requests.size() < 25 + (ph + 1) * PHASE_SIZE) begin
        kind = $urandom_range(99);
        if (kind < 45) begin
          sx = $urandom_range(COLS - 1);
          sy = $urandom_range(ROWS - 1);
          n_rows = $urandom_range(1, 16);
          for (r = 0; r < n_rows; r++) begin
            case ($urandom_range(7))
              0:       spr[r] = 8'h00;
              1:       spr[r] = 8'hFF;
              default: spr[r] = $urandom_range(255);
            endcase
            add_request(REQ_DRAW, sx, sy, r, spr[r], r == n_rows - 1);
          end
          // drawing it again restores the rows it covered, and its collision is checked too
          if ($urandom_range(2) == 0) begin
            for (r = 0; r < n_rows; r++)
              add_request(REQ_DRAW, sx, sy, r, spr[r], r == n_rows - 1);
          end
        end else if (kind < 65) begin
          repeat ($urandom_range(1, 4))
            add_request(REQ_SET, sx + $urandom_range(7), sy + $urandom_range(15),
                        $urandom_range(15), $urandom_range(255), $urandom_range(1));
        end else if (kind < 88) begin
          repeat ($urandom_range(1, 4))
            add_request(REQ_QUERY, sx + $urandom_range(7), sy + $urandom_range(n_rows),
                        $urandom_range(15), $urandom_range(255), $urandom_range(1));
        end else if (kind < 91) begin
          add_request(REQ_CLEAR, $urandom_range(63), $urandom_range(31),
                      $urandom_range(15), $urandom_range(255), $urandom_range(1));
        end else begin
          // stray rows out of sprite order
          add_request(req_t'($urandom_range(3)), $urandom_range(63), $urandom_range(31),
                      $urandom_range(15), $urandom_range(255), $urandom_range(1));
        end
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/msxf_pkg.sv
rtl/msxf_lane.sv
rtl/msxf_merge.sv
rtl/monochrome_sprite_xor_framebuffer_top.sv
sim/tb.sv
